// File: hdl/rmq_pkg.sv
// Shared types, constants and arithmetic helpers for the relative motion to quadrature block.
package rmq_pkg;

  localparam int ACCUM_BITS = 24;
  localparam int DELTA_BITS = 12;
  localparam int STEP_BITS  = 4;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic [STEP_BITS-1:0] STEP_SIZE_RESET = 4'd3;
  localparam logic                 REG_STEP_SIZE   = 1'b0;

  typedef logic signed [ACCUM_BITS-1:0] acc_t;
  typedef logic signed [ACCUM_BITS:0]   acc_ext_t;
  typedef logic        [ACCUM_BITS:0]   gap_mag_t;
  typedef logic        [ACCUM_BITS-1:0] acc_mag_t;
  typedef logic        [2*ACCUM_BITS-1:0] prod_t;
  typedef logic signed [DELTA_BITS:0]   delta_ext_t;

  typedef enum logic [1:0] {
    OP_X_MOTION = 2'd0,
    OP_Y_MOTION = 2'd1,
    OP_BUTTON   = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DELTA_BITS-1:0] motion_delta;
    logic                         button_down;
  } item_t;

  typedef struct packed {
    logic x_phase_a;
    logic x_phase_b;
    logic y_phase_a;
    logic y_phase_b;
    logic button_level_n;
    logic x_interrupt;
    logic y_interrupt;
    logic tick_request;
  } result_t;

  // Saturating add of a widened motion delta to an accumulator.
  function automatic acc_t sat_add(acc_t a, delta_ext_t d);
    acc_ext_t s;
    s = acc_ext_t'(a) + acc_ext_t'(d);
    if (s[ACCUM_BITS] != s[ACCUM_BITS-1]) begin
      return {s[ACCUM_BITS], {(ACCUM_BITS-1){~s[ACCUM_BITS]}}};
    end
    return s[ACCUM_BITS-1:0];
  endfunction

  function automatic acc_ext_t gap_diff(acc_t t, acc_t e);
    return acc_ext_t'(t) - acc_ext_t'(e);
  endfunction

  function automatic gap_mag_t ext_mag(acc_ext_t d);
    return d[ACCUM_BITS] ? gap_mag_t'(-d) : gap_mag_t'(d);
  endfunction

  // Two's complement negation of the most negative value still reads
  // correctly once the result is taken as unsigned.
  function automatic acc_mag_t acc_mag(acc_t v);
    return v[ACCUM_BITS-1] ? acc_mag_t'(-v) : acc_mag_t'(v);
  endfunction

endpackage

// File: hdl/rmq_cfg.sv
// Configuration register file holding the step size.
module rmq_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rmq_pkg::PADDR_BITS-1:0]       paddr,
  input  logic [rmq_pkg::PDATA_BITS-1:0]       pwdata,
  output logic [rmq_pkg::PDATA_BITS-1:0]       prdata,
  output logic                                 pready,
  output logic [rmq_pkg::STEP_BITS-1:0]        step_size
);

  logic reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite &&
                     (paddr[rmq_pkg::PADDR_BITS-1] == rmq_pkg::REG_STEP_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= rmq_pkg::STEP_SIZE_RESET;
    end else if (reg_write) begin
      step_size <= pwdata[rmq_pkg::STEP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[rmq_pkg::PADDR_BITS-1] == rmq_pkg::REG_STEP_SIZE) begin
      prdata = rmq_pkg::PDATA_BITS'(step_size);
    end
  end

endmodule

// File: hdl/rmq_core.sv
// Axis accumulators, phase state and the per-item update logic.
module rmq_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  rmq_pkg::item_t                item,
  input  logic [rmq_pkg::STEP_BITS-1:0] step_size,
  output rmq_pkg::result_t              result
);

  rmq_pkg::acc_t x_target, x_emitted, y_target, y_emitted;
  rmq_pkg::acc_t x_target_next, x_emitted_next, y_target_next, y_emitted_next;
  logic x_a_bit, x_b_bit, y_a_bit, y_b_bit, button_bit;
  logic x_a_bit_next, x_b_bit_next, y_a_bit_next, y_b_bit_next, button_bit_next;

  logic [rmq_pkg::STEP_BITS-1:0] st;
  rmq_pkg::gap_mag_t             st_ext, st_twice;
  rmq_pkg::acc_t                 st_acc;
  rmq_pkg::delta_ext_t           delta_ext;
  rmq_pkg::acc_ext_t             x_diff, y_diff;
  rmq_pkg::gap_mag_t             x_gap, y_gap;
  logic                          x_ok, y_ok, x_step, y_step, x_pos, y_pos;
  rmq_pkg::prod_t                prod_yx, prod_xy;
  rmq_pkg::acc_t                 motion_target;
  logic                          x_int, y_int, req;

  assign st        = (step_size == '0) ? rmq_pkg::STEP_BITS'(1) : step_size;
  assign st_ext    = rmq_pkg::gap_mag_t'(st);
  assign st_twice  = rmq_pkg::gap_mag_t'({st, 1'b0});
  assign st_acc    = rmq_pkg::acc_t'(st);
  assign delta_ext = rmq_pkg::delta_ext_t'(item.motion_delta);

  assign x_diff = rmq_pkg::gap_diff(x_target, x_emitted);
  assign y_diff = rmq_pkg::gap_diff(y_target, y_emitted);
  assign x_gap  = rmq_pkg::ext_mag(x_diff);
  assign y_gap  = rmq_pkg::ext_mag(y_diff);
  assign x_ok   = x_gap >= st_ext;
  assign y_ok   = y_gap >= st_ext;
  assign x_pos  = !x_diff[rmq_pkg::ACCUM_BITS] && (x_diff != '0);
  assign y_pos  = !y_diff[rmq_pkg::ACCUM_BITS] && (y_diff != '0);

  // Cross products pick the axis that lags its share of the motion. A cleared
  // y axis makes both products zero, so the x axis then wins.
  assign prod_yx = rmq_pkg::acc_mag(y_target) * rmq_pkg::acc_mag(x_emitted);
  assign prod_xy = rmq_pkg::acc_mag(x_target) * rmq_pkg::acc_mag(y_emitted);
  assign x_step  = x_ok && (!y_ok || (prod_yx <= prod_xy));
  assign y_step  = !x_step && y_ok;

  always_comb begin
    x_target_next   = x_target;
    x_emitted_next  = x_emitted;
    y_target_next   = y_target;
    y_emitted_next  = y_emitted;
    x_a_bit_next    = x_a_bit;
    x_b_bit_next    = x_b_bit;
    y_a_bit_next    = y_a_bit;
    y_b_bit_next    = y_b_bit;
    button_bit_next = button_bit;
    x_int           = 1'b0;
    y_int           = 1'b0;
    req             = 1'b0;
    motion_target   = '0;
    case (item.op)
      rmq_pkg::OP_X_MOTION: begin
        if (item.motion_delta != '0) begin
          motion_target = rmq_pkg::sat_add(x_target, delta_ext);
          x_target_next = motion_target;
          req = rmq_pkg::ext_mag(rmq_pkg::gap_diff(motion_target, x_emitted)) >= st_ext;
        end
      end
      rmq_pkg::OP_Y_MOTION: begin
        if (item.motion_delta != '0) begin
          motion_target = rmq_pkg::sat_add(y_target, -delta_ext);
          y_target_next = motion_target;
          req = rmq_pkg::ext_mag(rmq_pkg::gap_diff(motion_target, y_emitted)) >= st_ext;
        end
      end
      rmq_pkg::OP_BUTTON: begin
        button_bit_next = !item.button_down;
      end
      rmq_pkg::OP_TICK: begin
        if (!x_ok) begin
          x_target_next  = '0;
          x_emitted_next = '0;
        end
        if (!y_ok) begin
          y_target_next  = '0;
          y_emitted_next = '0;
        end
        // A step never passes the target, so the emitted position needs no
        // saturation here.
        if (x_step) begin
          x_a_bit_next   = !x_a_bit;
          x_b_bit_next   = x_pos ? x_a_bit : !x_a_bit;
          x_emitted_next = x_pos ? x_emitted + st_acc : x_emitted - st_acc;
          x_int          = 1'b1;
        end
        if (y_step) begin
          y_a_bit_next   = !y_a_bit;
          y_b_bit_next   = y_pos ? y_a_bit : !y_a_bit;
          y_emitted_next = y_pos ? y_emitted + st_acc : y_emitted - st_acc;
          y_int          = 1'b1;
        end
        req = (x_step ? (x_gap >= st_twice) : x_ok) ||
              (y_step ? (y_gap >= st_twice) : y_ok);
      end
      default: begin
        req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_target   <= '0;
      x_emitted  <= '0;
      y_target   <= '0;
      y_emitted  <= '0;
      x_a_bit    <= 1'b0;
      x_b_bit    <= 1'b0;
      y_a_bit    <= 1'b0;
      y_b_bit    <= 1'b0;
      button_bit <= 1'b1;
    end else if (advance) begin
      x_target   <= x_target_next;
      x_emitted  <= x_emitted_next;
      y_target   <= y_target_next;
      y_emitted  <= y_emitted_next;
      x_a_bit    <= x_a_bit_next;
      x_b_bit    <= x_b_bit_next;
      y_a_bit    <= y_a_bit_next;
      y_b_bit    <= y_b_bit_next;
      button_bit <= button_bit_next;
    end
  end

  always_comb begin
    result.x_phase_a      = x_a_bit_next;
    result.x_phase_b      = x_b_bit_next;
    result.y_phase_a      = y_a_bit_next;
    result.y_phase_b      = y_b_bit_next;
    result.button_level_n = button_bit_next;
    result.x_interrupt    = x_int;
    result.y_interrupt    = y_int;
    result.tick_request   = req;
  end

endmodule

// File: hdl/relative_motion_to_quadrature.sv
// Top level: input register, update logic, result register and configuration port.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+------------------------------------------
//   input    | in_valid / in_ready    | op, motion_delta, button_down
//   result   | out_valid / out_ready  | x/y phase a/b, button_level_n, interrupts,
//            |                        | tick_request
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// Each item passes through the input register and then the result register, so a result
// is offered once its item moves from the input register into the result register;
// one item is taken per cycle unless a stalled result holds the input register.
// The update logic (gap compare, cross products, step) sits between the two registers.
// Reset clears both valid flags, the axis state and sets step_size to 3.
// A stalled result holds the input register; a new item is still taken while only
// the result register is full.
module relative_motion_to_quadrature (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            op,
  input  logic signed [rmq_pkg::DELTA_BITS-1:0] motion_delta,
  input  logic                                  button_down,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  x_phase_a,
  output logic                                  x_phase_b,
  output logic                                  y_phase_a,
  output logic                                  y_phase_b,
  output logic                                  button_level_n,
  output logic                                  x_interrupt,
  output logic                                  y_interrupt,
  output logic                                  tick_request,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rmq_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [rmq_pkg::PDATA_BITS-1:0]        pwdata,
  output logic [rmq_pkg::PDATA_BITS-1:0]        prdata,
  output logic                                  pready
);

  logic                          item_valid;
  rmq_pkg::item_t                item;
  logic                          advance;
  logic [rmq_pkg::STEP_BITS-1:0] step_size;
  rmq_pkg::result_t              result;
  rmq_pkg::result_t              result_q;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op           <= rmq_pkg::op_t'(op);
      item.motion_delta <= motion_delta;
      item.button_down  <= button_down;
    end
    if (advance) begin
      result_q <= result;
    end
  end

  rmq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .step_size (step_size)
  );

  rmq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .step_size (step_size),
    .result    (result)
  );

  assign x_phase_a      = result_q.x_phase_a;
  assign x_phase_b      = result_q.x_phase_b;
  assign y_phase_a      = result_q.y_phase_a;
  assign y_phase_b      = result_q.y_phase_b;
  assign button_level_n = result_q.button_level_n;
  assign x_interrupt    = result_q.x_interrupt;
  assign y_interrupt    = result_q.y_interrupt;
  assign tick_request   = result_q.tick_request;

endmodule
